/* rtl/fixed_point_alu_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU
// Clocked concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// check a condition at every edge
`define FPA_CHECK(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check a consequence in the cycle after a condition
`define FPA_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Command and status codes shared by the ALU and its testbench.
// ----------------------------------------------------------------------------
package fpa_pkg;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_GT       = 4'd4,
      CMD_LT       = 4'd5,
      CMD_GE       = 4'd6,
      CMD_LE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_MIN      = 4'd10,
      CMD_MAX      = 4'd11,
      CMD_INC      = 4'd12,
      CMD_DEC      = 4'd13,
      CMD_FROM_INT = 4'd14,
      CMD_TO_INT   = 4'd15
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   localparam int FIELD_WIDTH = 32;

endpackage

/* rtl/fixed_point_alu.sv */
// Throughput: one item per cycle while the result side is not stalling.
// The restoring divider takes one quotient bit per stage.
// Stalls on the result side freeze the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; no other state.
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Pipelined signed fixed-point ALU with saturation, rounded multiply and divide.
// ----------------------------------------------------------------------------
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRACTION_BITS = 8,
   parameter int DATA_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd [3:0], operand_a [35:4], operand_b [67:36], zero [71:68]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value [31:0], compare_true [32], status [34:33], zero [39:35]
   output logic [39:0] rsp_tdata
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int NW = W + F;
   localparam int IW = (W < FIELD_WIDTH) ? W : FIELD_WIDTH;

   typedef struct packed {
      logic          valid;
      logic          is_div;
      logic          is_mul;
      logic          neg;
      logic [W-1:0]  ub;
      logic [NW-1:0] num;
      logic [W:0]    rem;
      logic [W-1:0]  res;
      logic          cmp;
      status_type    stat;
   } stage_type;

   logic [W-1:0] signb;
   assign signb = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W-1:0] mag(input logic [W-1:0] x);
      logic [W-1:0] m;
      m = x[W-1] ? (~x + 1'b1) : x;
      return m;
   endfunction

   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   // input register
   logic         s1_valid_ff;
   cmd_type      s1_cmd_ff;
   logic [W-1:0] s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
      if (adv) begin
         s1_cmd_ff <= cmd_type'(req_tdata[3:0]);
         s1_a_ff   <= W'($signed(req_tdata[4 +: IW]));
         s1_b_ff   <= W'($signed(req_tdata[36 +: IW]));
      end
   end

   // decode, and the operations computed directly from the operands
   stage_type      p_ff [NW+1];
   stage_type      p_in [NW+1];
   stage_type      p0_in;
   logic [2*W-1:0] prod_ff, prod_in;

   always_comb begin
      logic signed [W-1:0] sa, sb;
      logic signed [W:0]   sum;
      logic [W-1:0]        ma, mb, lim;
      logic [NW-1:0]       fi;
      logic                addlike, sub, neg_a;
      sa      = $signed(s1_a_ff);
      sb      = $signed(s1_b_ff);
      ma      = mag(s1_a_ff);
      mb      = mag(s1_b_ff);
      neg_a   = s1_a_ff[W-1];
      addlike = 1'b0;
      sub     = 1'b0;
      p0_in = '0;
      p0_in.valid  = s1_valid_ff;
      p0_in.neg    = s1_a_ff[W-1] ^ s1_b_ff[W-1];
      p0_in.ub     = mb;
      p0_in.num    = {ma, {F{1'b0}}};
      p0_in.stat   = ST_OK;
      prod_in = ma * mb;
      case (s1_cmd_ff)
         CMD_ADD: addlike = 1'b1;
         CMD_SUB: begin addlike = 1'b1; sub = 1'b1; end
         CMD_INC: addlike = 1'b1;
         CMD_DEC: begin addlike = 1'b1; sub = 1'b1; end
         default: ;
      endcase
      if (s1_cmd_ff == CMD_INC || s1_cmd_ff == CMD_DEC) begin
         sb = W'(1);
      end
      sum = sub ? ((W+1)'(sa) - (W+1)'(sb)) : ((W+1)'(sa) + (W+1)'(sb));
      lim = signb - W'(!neg_a);
      fi  = {ma, {F{1'b0}}};
      case (s1_cmd_ff)
         CMD_MUL: p0_in.is_mul = 1'b1;
         CMD_DIV: begin
            if (s1_b_ff == '0) begin
               p0_in.stat = ST_DIVZ;
               p0_in.res  = (s1_a_ff == '0) ? '0 : (neg_a ? signb : ~signb);
            end else begin
               p0_in.is_div = 1'b1;
            end
         end
         CMD_GT:  p0_in.cmp = sa > sb;
         CMD_LT:  p0_in.cmp = sa < sb;
         CMD_GE:  p0_in.cmp = sa >= sb;
         CMD_LE:  p0_in.cmp = sa <= sb;
         CMD_EQ:  p0_in.cmp = sa == sb;
         CMD_NE:  p0_in.cmp = sa != sb;
         CMD_MIN: p0_in.res = (sa < sb) ? s1_a_ff : s1_b_ff;
         CMD_MAX: p0_in.res = (sa > sb) ? s1_a_ff : s1_b_ff;
         CMD_FROM_INT: begin
            if (fi > NW'(lim)) begin
               p0_in.stat = ST_OVF;
               p0_in.res  = neg_a ? signb : ~signb;
            end else begin
               p0_in.res  = neg_a ? (~fi[W-1:0] + 1'b1) : fi[W-1:0];
            end
         end
         CMD_TO_INT: p0_in.res = W'(sa >>> F);
         default: begin
            if (sum[W] != sum[W-1]) begin
               p0_in.stat = ST_OVF;
               p0_in.res  = neg_a ? signb : ~signb;
            end else begin
               p0_in.res  = sum[W-1:0];
            end
         end
      endcase
      if (!addlike && s1_cmd_ff != CMD_MUL && s1_cmd_ff != CMD_DIV &&
          s1_cmd_ff != CMD_FROM_INT && s1_cmd_ff != CMD_TO_INT &&
          s1_cmd_ff != CMD_MIN && s1_cmd_ff != CMD_MAX) begin
         p0_in.res = '0;
      end
   end

   // divider steps, multiply rounding in the first step
   always_comb begin
      logic [W:0]     r2;
      logic           qb;
      logic [2*W-1:0] pr, sh;
      logic [W-1:0]   lim;
      p_in[0] = p0_in;
      for (int k = 0; k < NW; k++) begin
         p_in[k+1] = p_ff[k];
         r2 = {p_ff[k].rem[W-1:0], p_ff[k].num[NW-1]};
         qb = r2 >= {1'b0, p_ff[k].ub};
         if (qb) begin
            r2 = r2 - {1'b0, p_ff[k].ub};
         end
         p_in[k+1].rem = r2;
         p_in[k+1].num = {p_ff[k].num[NW-2:0], qb};
      end
      pr  = prod_ff + (2*W)'({1'b1, {(F-1){1'b0}}});
      sh  = pr >> F;
      lim = signb - W'(!p_ff[0].neg);
      if (p_ff[0].is_mul) begin
         if (sh > (2*W)'(lim)) begin
            p_in[1].stat = ST_OVF;
            p_in[1].res  = p_ff[0].neg ? signb : ~signb;
         end else begin
            p_in[1].res  = p_ff[0].neg ? (~sh[W-1:0] + 1'b1) : sh[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
      for (int k = 0; k <= NW; k++) begin
         if (reset) begin
            p_ff[k].valid <= 1'b0;
         end else if (adv) begin
            p_ff[k] <= p_in[k];
         end
      end
   end

   // divide rounding and saturation, output register
   logic [W-1:0] res_in, res_ff;
   logic         cmp_ff;
   status_type   stat_in, stat_ff;

   always_comb begin
      logic [NW:0]  qr;
      logic [W:0]   diff;
      logic [W-1:0] lim;
      stage_type    f;
      f       = p_ff[NW];
      res_in  = f.res;
      stat_in = f.stat;
      diff    = {1'b0, f.ub} - f.rem;
      qr      = {1'b0, f.num} + (NW+1)'(f.rem >= diff);
      lim     = signb - W'(!f.neg);
      if (f.is_div) begin
         if (qr > (NW+1)'(lim)) begin
            stat_in = ST_OVF;
            res_in  = f.neg ? signb : ~signb;
         end else begin
            stat_in = ST_OK;
            res_in  = f.neg ? (~qr[W-1:0] + 1'b1) : qr[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p_ff[NW].valid;
      end
      if (adv) begin
         res_ff  <= res_in;
         cmp_ff  <= p_ff[NW].cmp;
         stat_ff <= stat_in;
      end
   end

   assign rsp_tdata = {5'd0, stat_ff, cmp_ff, FIELD_WIDTH'(res_ff)};

`include "fixed_point_alu_assert.svh"

   `FPA_CHECK(a_status_code, !rsp_tvalid || rsp_tdata[34:33] != 2'b11, "bad status code")
   `FPA_CHECK(a_cmp_clean, !(rsp_tvalid && rsp_tdata[32]) || rsp_tdata[34:0] == {3'b001, 32'd0}, "bad compare")
   `FPA_CHECK_NEXT(a_stall_hold, !adv, $stable(s1_valid_ff) && $stable(p_ff[0].valid), "stall moved")
   `FPA_CHECK_NEXT(a_advance, adv && p_ff[0].valid, p_ff[1].valid, "item lost in pipeline")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives command items through the ALU stream port with random gaps, predicts
// each result with a local Q24.8 model and checks results in order.
// ----------------------------------------------------------------------------
class alu_scoreboard;
   logic [34:0] pending[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   static function logic [63:0] clamp_mag(bit neg, logic [127:0] mag, ref logic [1:0] st);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (mag > lim) begin
         st = fpa_pkg::ST_OVF;
         return neg ? 64'hffff_ffff_8000_0000 : 64'h7fff_ffff;
      end
      return neg ? -mag[63:0] : mag[63:0];
   endfunction

   static function logic [34:0] compute(logic [3:0] cmd, logic signed [31:0] a,
                                        logic signed [31:0] b);
      logic signed [63:0] sa, sb, wide;
      logic [127:0] ma, mb, prod, num, quo, rem;
      logic [63:0] res;
      logic [1:0] st;
      bit cmp;
      sa = a;
      sb = b;
      res = 0;
      st = fpa_pkg::ST_OK;
      cmp = 0;
      ma = sa < 0 ? -sa : sa;
      mb = sb < 0 ? -sb : sb;
      case (cmd)
         fpa_pkg::CMD_ADD: res = clamp_mag(sa + sb < 0, (sa + sb < 0) ? -(sa + sb) : sa + sb, st);
         fpa_pkg::CMD_SUB: res = clamp_mag(sa - sb < 0, (sa - sb < 0) ? -(sa - sb) : sa - sb, st);
         fpa_pkg::CMD_INC: res = clamp_mag(sa + 1 < 0, (sa + 1 < 0) ? -(sa + 1) : sa + 1, st);
         fpa_pkg::CMD_DEC: res = clamp_mag(sa - 1 < 0, (sa - 1 < 0) ? -(sa - 1) : sa - 1, st);
         fpa_pkg::CMD_MUL: begin
            prod = (ma * mb + 128'd128) >> 8;
            res = clamp_mag((sa < 0) != (sb < 0), prod, st);
         end
         fpa_pkg::CMD_DIV: begin
            if (sb == 0) begin
               st = fpa_pkg::ST_DIVZ;
               res = sa > 0 ? 64'h7fff_ffff : (sa < 0 ? 64'h8000_0000 : 64'h0);
            end else begin
               num = ma << 8;
               quo = num / mb;
               rem = num % mb;
               if (rem >= mb - rem) quo = quo + 1;
               res = clamp_mag((sa < 0) != (sb < 0), quo, st);
            end
         end
         fpa_pkg::CMD_GT: cmp = sa > sb;
         fpa_pkg::CMD_LT: cmp = sa < sb;
         fpa_pkg::CMD_GE: cmp = sa >= sb;
         fpa_pkg::CMD_LE: cmp = sa <= sb;
         fpa_pkg::CMD_EQ: cmp = sa == sb;
         fpa_pkg::CMD_NE: cmp = sa != sb;
         fpa_pkg::CMD_MIN: res = sa < sb ? sa : sb;
         fpa_pkg::CMD_MAX: res = sa > sb ? sa : sb;
         fpa_pkg::CMD_FROM_INT: res = clamp_mag(sa < 0, ma << 8, st);
         default: begin
            wide = sa >>> 8;
            res = wide;
         end
      endcase
      return {st, cmp, res[31:0]};
   endfunction

   function void note_item(logic [71:0] d);
      pending.push_back(compute(d[3:0], d[35:4], d[67:36]));
   endfunction

   function void check_result(logic [39:0] d);
      logic [34:0] exp_r;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, d);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (d[31:0] !== exp_r[31:0]) begin
         $display("%0t: result_value expected %h actual %h", $time, exp_r[31:0], d[31:0]);
         errors++;
      end
      if (d[32] !== exp_r[32]) begin
         $display("%0t: compare_true expected %b actual %b", $time, exp_r[32], d[32]);
         errors++;
      end
      if (d[34:33] !== exp_r[34:33]) begin
         $display("%0t: status expected %0d actual %0d", $time, exp_r[34:33], d[34:33]);
         errors++;
      end
      if (d[39:35] !== 5'd0) begin
         $display("%0t: pad expected 0 actual %h", $time, d[39:35]);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import fpa_pkg::*;

   localparam int LATENCY = 43;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [39:0] rsp_tdata;

   alu_scoreboard board = new();
   int cycles = 0;
   int hold_off = 0;
   bit stim_done = 0;

   fixed_point_alu dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_item(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, one long hold-off mid-run, then an always-ready window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (cycles == 3000) begin
         hold_off <= 400;
         rsp_tready <= 0;
      end else if (cycles > 8000 && cycles < 12000) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h100 : 32'hffff_ff00;
         4, 5: return $urandom_range(0, 4095) - 2048;
         6: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : -$urandom_range(0, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0 && !(cycles > 8000 && cycles < 12000)) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, b, a, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [31:0] ext[6];
      cmd_type c;
      ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'hffff_ffff, 32'h100};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(CMD_ADD, 32'h7fff_ffff, 32'h1);
      send_item(CMD_SUB, 32'h8000_0000, 32'h1);
      send_item(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(CMD_MUL, 32'h180, 32'hffff_ff80);
      send_item(CMD_MUL, 32'h1, 32'h80);
      send_item(CMD_DIV, 32'h100, 32'h0);
      send_item(CMD_DIV, 32'hffff_ff00, 32'h0);
      send_item(CMD_DIV, 32'h0, 32'h0);
      send_item(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_item(CMD_DIV, 32'h100, 32'h300);
      send_item(CMD_DIV, 32'hffff_ff00, 32'h200);
      send_item(CMD_INC, 32'h7fff_ffff, 32'h0);
      send_item(CMD_DEC, 32'h8000_0000, 32'h0);
      send_item(CMD_FROM_INT, 32'h0080_0000, 32'h0);
      send_item(CMD_FROM_INT, 32'hff80_0000, 32'h0);
      send_item(CMD_FROM_INT, 32'hff7f_ffff, 32'h0);
      send_item(CMD_TO_INT, 32'hffff_ffff, 32'h0);
      send_item(CMD_TO_INT, 32'h7fff_ffff, 32'h0);
      for (int k = 0; k < 16; k++) begin
         c = cmd_type'(k);
         if (k >= 4 && k <= 11) send_item(c, ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]);
      end
      for (int n = 0; n < 1650; n++)
         send_item($urandom_range(0, 15), pick_operand(), pick_operand());
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
